// ===== src/e2q_pkg.sv =====
package e2q_pkg;

    localparam int ATAN_ENTRIES        = 24;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_LIMIT         = 23040;
    localparam int CORDIC_GAIN_Q30     = 652032874;
    localparam int POS_W               = 32;
    localparam int ANG_W               = 16;
    localparam int CW                  = 32;
    localparam int Q15_W               = 16;

    typedef struct packed {
        logic signed [Q15_W-1:0] w;
        logic signed [Q15_W-1:0] x;
        logic signed [Q15_W-1:0] y;
        logic signed [Q15_W-1:0] z;
    } t_quat;

    // atan(2^-i) in degrees, 2^-23 degree units
    function automatic logic signed [CW-1:0] atan_q23(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 32'sd377487360;
            1:  v = 32'sd222843801;
            2:  v = 32'sd117744544;
            3:  v = 32'sd59768969;
            4:  v = 32'sd30000467;
            5:  v = 32'sd15014858;
            6:  v = 32'sd7509261;
            7:  v = 32'sd3754860;
            8:  v = 32'sd1877459;
            9:  v = 32'sd938733;
            10: v = 32'sd469367;
            11: v = 32'sd234683;
            12: v = 32'sd117342;
            13: v = 32'sd58671;
            14: v = 32'sd29335;
            15: v = 32'sd14668;
            16: v = 32'sd7334;
            17: v = 32'sd3667;
            18: v = 32'sd1833;
            19: v = 32'sd917;
            20: v = 32'sd458;
            21: v = 32'sd229;
            22: v = 32'sd115;
            23: v = 32'sd57;
            default: v = '0;
        endcase
        return v;
    endfunction

    // q2.30 product back to q2.30, halves round up
    function automatic logic signed [CW-1:0] rnd30(input logic signed [2*CW-1:0] p);
        logic signed [2*CW-1:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return t[CW-1:0];
    endfunction

    // sum of two q2.30 terms to saturated q1.15
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CW:0] v);
        logic signed [CW:0] t;
        logic signed [Q15_W-1:0] q;
        t = (v + 33'sd16384) >>> 15;
        if (t > 33'sd32767) begin
            q = 16'sh7fff;
        end else if (t < -33'sd32768) begin
            q = 16'sh8000;
        end else begin
            q = t[Q15_W-1:0];
        end
        return q;
    endfunction

endpackage

// ===== src/e2q_cell.sv =====
module e2q_cell #(
    parameter int STAGE = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [e2q_pkg::CW-1:0] i_x,
    input  logic signed [e2q_pkg::CW-1:0] i_y,
    input  logic signed [e2q_pkg::CW-1:0] i_r,
    output logic signed [e2q_pkg::CW-1:0] o_x,
    output logic signed [e2q_pkg::CW-1:0] o_y,
    output logic signed [e2q_pkg::CW-1:0] o_r
);
    import e2q_pkg::*;

    localparam logic signed [CW-1:0] ATAN = atan_q23(STAGE);

    logic signed [CW-1:0] r_x, r_y, r_r;
    logic signed [CW-1:0] n_x, n_y, n_r;
    logic signed [CW-1:0] w_dx, w_dy;

    always_comb begin
        w_dx = i_y >>> STAGE;
        w_dy = i_x >>> STAGE;
        if (!i_r[CW-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_r = i_r - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_r = i_r + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_r <= n_r;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_r = r_r;

endmodule

// ===== src/e2q_quat.sv =====
module e2q_quat (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [e2q_pkg::CW-1:0] i_cr,
    input  logic signed [e2q_pkg::CW-1:0] i_sr,
    input  logic signed [e2q_pkg::CW-1:0] i_cp,
    input  logic signed [e2q_pkg::CW-1:0] i_sp,
    input  logic signed [e2q_pkg::CW-1:0] i_cy,
    input  logic signed [e2q_pkg::CW-1:0] i_sy,
    output e2q_pkg::t_quat                o_q
);
    import e2q_pkg::*;

    logic signed [2*CW-1:0] r_crcp, r_srsp, r_srcp, r_crsp;
    logic signed [CW-1:0]   r_cy, r_sy;
    logic signed [2*CW-1:0] r_w1, r_w2, r_x1, r_x2, r_y1, r_y2, r_z1, r_z2;
    logic signed [CW-1:0]   w_crcp, w_srsp, w_srcp, w_crsp;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crcp <= i_cr * i_cp;
            r_srsp <= i_sr * i_sp;
            r_srcp <= i_sr * i_cp;
            r_crsp <= i_cr * i_sp;
            r_cy   <= i_cy;
            r_sy   <= i_sy;
        end
    end

    assign w_crcp = rnd30(r_crcp);
    assign w_srsp = rnd30(r_srsp);
    assign w_srcp = rnd30(r_srcp);
    assign w_crsp = rnd30(r_crsp);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1 <= w_crcp * r_cy;
            r_w2 <= w_srsp * r_sy;
            r_x1 <= w_srcp * r_cy;
            r_x2 <= w_crsp * r_sy;
            r_y1 <= w_crsp * r_cy;
            r_y2 <= w_srcp * r_sy;
            r_z1 <= w_crcp * r_sy;
            r_z2 <= w_srsp * r_cy;
        end
    end

    function automatic logic signed [CW:0] ext(input logic signed [CW-1:0] v);
        return {v[CW-1], v};
    endfunction

    always_comb begin
        o_q.w = to_q15(ext(rnd30(r_w1)) + ext(rnd30(r_w2)));
        o_q.x = to_q15(ext(rnd30(r_x1)) - ext(rnd30(r_x2)));
        o_q.y = to_q15(ext(rnd30(r_y1)) + ext(rnd30(r_y2)));
        o_q.z = to_q15(ext(rnd30(r_z1)) - ext(rnd30(r_z2)));
    end

endmodule

// ===== src/euler_to_quaternion_core.sv =====
// euler to quaternion, zyx convention
// s_axis carries one pose per item: tdata = pos_x, pos_y, pos_z (32 bits each),
// then roll, pitch, yaw (signed q9.7 degrees), 144 bits in all.
// m_axis returns one item per pose: tdata = out_x, out_y, out_z, then
// quat_w, quat_x, quat_y, quat_z (signed q1.15), 160 bits in all.
// three rows of cordic cells, one row per angle, one cell per stage, turn
// the half angles into sine and cosine; a two-stage multiplier tree forms the
// triple products and the sums land in the output register.
// throughput: one item per cycle while s_axis_tready is high; every cell and multiplier is pipelined.
// the output register has a skid stage behind it, so one more item is taken
// while a result waits; with both full, s_axis_tready drops and the whole
// pipeline holds until m_axis_tready returns.
// reset empties the pipeline and both output slots; no state otherwise.
module euler_to_quaternion_core #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, roll_deg, pitch_deg, yaw_deg
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z, quat_w, quat_x, quat_y, quat_z
    output logic [159:0] m_axis_tdata
);
    import e2q_pkg::*;

    localparam int NST   = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int DLY   = NST + 2;
    localparam int POS3W = 3 * POS_W;

    logic w_en;
    logic signed [CW-1:0] w_x [3][NST+1];
    logic signed [CW-1:0] w_y [3][NST+1];
    logic signed [CW-1:0] w_r [3][NST+1];
    logic r_vld [DLY];
    logic [POS3W-1:0] r_pos [DLY];
    t_quat w_q;
    logic [159:0] w_res;
    logic r_out_v, r_skid_v;
    logic [159:0] r_out, r_skid;

    function automatic logic signed [CW-1:0] start_res(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] c;
        logic signed [CW-1:0] e;
        if (a > 16'(ANGLE_LIMIT)) begin
            c = 16'(ANGLE_LIMIT);
        end else if (a < -16'(ANGLE_LIMIT)) begin
            c = -16'(ANGLE_LIMIT);
        end else begin
            c = a;
        end
        e = {{(CW-ANG_W){c[ANG_W-1]}}, c};
        return e <<< 15;
    endfunction

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    genvar g, k;
    generate
        for (g = 0; g < 3; g++) begin : g_row
            assign w_x[g][0] = CW'(CORDIC_GAIN_Q30);
            assign w_y[g][0] = '0;
            assign w_r[g][0] = start_res(s_axis_tdata[POS3W + g*ANG_W +: ANG_W]);
            for (k = 0; k < NST; k++) begin : g_cell
                e2q_cell #(.STAGE(k)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_x   (w_x[g][k]),
                    .i_y   (w_y[g][k]),
                    .i_r   (w_r[g][k]),
                    .o_x   (w_x[g][k+1]),
                    .o_y   (w_y[g][k+1]),
                    .o_r   (w_r[g][k+1])
                );
            end
        end
    endgenerate

    e2q_quat u_quat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cr  (w_x[0][NST]),
        .i_sr  (w_y[0][NST]),
        .i_cp  (w_x[1][NST]),
        .i_sp  (w_y[1][NST]),
        .i_cy  (w_x[2][NST]),
        .i_sy  (w_y[2][NST]),
        .o_q   (w_q)
    );

    // valid and position ride alongside the cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < DLY; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos[0] <= s_axis_tdata[POS3W-1:0];
            for (int i = 1; i < DLY; i++) begin
                r_pos[i] <= r_pos[i-1];
            end
        end
    end

    assign w_res = {w_q.z, w_q.y, w_q.x, w_q.w, r_pos[DLY-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            r_out_v  <= r_skid_v || (r_vld[DLY-1] && w_en);
            r_skid_v <= 1'b0;
        end else if (r_vld[DLY-1] && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || m_axis_tready) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_en) begin
            r_skid <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid slot full while output slot empty");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_out_v && r_skid_v))
        else $error("input stalled with room downstream");
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DLY-1] && w_en && r_out_v && !m_axis_tready) |=> r_skid_v)
        else $error("finished item dropped");
`endif

endmodule
